@@ design/bal_pkg.sv @@
// Shared types and codes for the bounded array list.
package bal_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 4;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 5;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

  typedef logic [VAL_W-1:0] val_t;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic valid;  // cell lies below the count
    logic wr;     // load the broadcast value
    logic sh;     // take the entry of the next cell up
  } cell_ctl_t;

endpackage

@@ design/bal_if.sv @@
// Channel interfaces: operation input, result output and capacity write.
interface bal_in_if import bal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;
  logic [IDX_W-1:0]        index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface bal_out_if import bal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output status, output read_value, output count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  output ready);
endinterface

interface bal_cfg_if import bal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bounded_array_list.sv @@
// Top level of the bounded array list: controller and chain of cells.
//
// Usage:
//   in_bus carries one operation a beat: op (push, remove by value, read by
//   index), value and index. out_bus returns one result beat per operation:
//   status, read_value and the count after the operation. cfg_bus writes the
//   capacity register; it is always ready, and the user must write it only
//   while idle: the block does not enforce this. An accepted operation is
//   held in the operation register and executed from there; its result is
//   registered in the result register behind out_bus.valid. No operation is
//   accepted while the single operation register still holds one. All cells
//   compare, search and shift in parallel within the execute cycle.
//   A stalled receiver holds the result register; one more operation may be
//   accepted and waits until the result beat is taken.
//   Reset: count 0, capacity 16, no beat pending. Cell contents are not
//   cleared; a cell is only read after a push has written it.
module bounded_array_list import bal_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  bal_in_if.sink   in_bus,
  bal_out_if.source out_bus,
  bal_cfg_if.sink  cfg_bus
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int RDN = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);

  logic [CAP_W-1:0] capacity_r;
  logic [CW-1:0]    used_r, used_nxt;
  logic             item_v_r, item_v_nxt;
  logic [OP_W-1:0]  op_r;
  val_t             value_r;
  logic [IDX_W-1:0] index_r;
  logic             out_v_r, out_v_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  val_t             rd_r, rd_nxt;
  logic [CNT_W-1:0] count_r;

  logic             in_fire, exec, hit, push_ok;
  logic [LW-1:0]    limit;
  val_t             entry   [DEPTH];
  logic [DEPTH-1:0] match_vec;
  cell_ctl_t        ctl     [DEPTH];

  assign in_bus.ready  = !item_v_r;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign exec          = item_v_r && (!out_v_r || out_bus.ready);
  assign cfg_bus.ready = 1'b1;

  assign limit   = (LW'(capacity_r) < LW'(DEPTH)) ? LW'(capacity_r) : LW'(DEPTH);
  assign push_ok = LW'(used_r) < limit;
  assign hit     = |match_vec;

  // Cell chain: push loads the cell at the count; remove shifts every cell but
  // the last at or above the first match down by one.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic at_or_above;
    assign at_or_above = |match_vec[i:0];
    assign ctl[i].valid = CW'(i) < used_r;
    assign ctl[i].wr = exec && (op_r == OP_PUSH) && push_ok && (used_r == CW'(i));
    if (i < DEPTH - 1) begin : g_mid
      assign ctl[i].sh = exec && (op_r == OP_REMOVE) && at_or_above;
      bal_cell u_cell (
        .clk          (clk),
        .ctl          (ctl[i]),
        .key_i        (value_r),
        .next_entry_i (entry[i+1]),
        .entry_o      (entry[i]),
        .match_o      (match_vec[i])
      );
    end else begin : g_last
      assign ctl[i].sh = 1'b0;
      bal_cell u_cell (
        .clk          (clk),
        .ctl          (ctl[i]),
        .key_i        (value_r),
        .next_entry_i (value_r),
        .entry_o      (entry[i]),
        .match_o      (match_vec[i])
      );
    end
  end

  always_comb begin
    used_nxt   = used_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    case (op_r)
      OP_PUSH: begin
        if (push_ok) begin
          used_nxt = used_r + CW'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          used_nxt = used_r - CW'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if ((LW'(index_r) >= LW'(used_r)) || (LW'(index_r) >= LW'(DEPTH))) begin
          status_nxt = ST_RANGE;
        end else begin
          for (int i = 0; i < RDN; i++) begin
            if (index_r == IDX_W'(i)) begin
              rd_nxt = entry[i];
            end
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_fire) begin
      item_v_nxt = 1'b1;
    end else if (exec) begin
      item_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (exec) begin
      out_v_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      used_r     <= '0;
      item_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        capacity_r <= cfg_bus.data;
      end
      if (exec) begin
        used_r <= used_nxt;
      end
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers: hold the operation and the result beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_bus.op;
      value_r <= in_bus.value;
      index_r <= in_bus.index;
    end
    if (exec) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      count_r  <= CNT_W'(used_nxt);
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.status     = status_r;
  assign out_bus.read_value = rd_r;
  assign out_bus.count      = count_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_v_r)
    else $error("executed operation left no result beat");

  a_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (item_v_r && !in_bus.ready))
    else $error("accepted operation not held");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (op_r == OP_REMOVE) && hit) |=> (used_r == $past(used_r) - CW'(1)))
    else $error("remove hit did not drop the count");

endmodule

@@ design/bal_cell.sv @@
// One list cell: holds an entry, compares it with the key, shifts or loads.
module bal_cell import bal_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  val_t      key_i,
  input  val_t      next_entry_i,
  output val_t      entry_o,
  output logic      match_o
);

  val_t entry_r;
  val_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.wr) begin
      entry_nxt = key_i;
    end else if (ctl.sh) begin
      entry_nxt = next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign match_o = ctl.valid && (entry_r == key_i);

endmodule
